@@ rtl/core/cpu8alu_pkg.sv @@
// Package for the 8-bit ALU: operation codes, status bit positions and the
// packed request and response types. Depends on nothing.
`timescale 1ns / 1ps

package cpu8alu_pkg;

   // Status byte bit positions.
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   // BCD digit correction constants.
   localparam logic [5:0] BCD_MAX_DIGIT = 6'd9;
   localparam logic [5:0] BCD_ADJUST    = 6'd6;
   localparam logic [5:0] BCD_NIBBLE_TOP = 6'd15;

   typedef enum logic [3:0] {
      MODE_OR   = 4'd0,
      MODE_AND  = 4'd1,
      MODE_XOR  = 4'd2,
      MODE_ADC  = 4'd3,
      MODE_LOAD = 4'd4,
      MODE_CMP  = 4'd5,
      MODE_SBC  = 4'd6,
      MODE_ASL  = 4'd7,
      MODE_ROL  = 4'd8,
      MODE_LSR  = 4'd9,
      MODE_ROR  = 4'd10,
      MODE_INC  = 4'd11,
      MODE_DEC  = 4'd12,
      MODE_BIT  = 4'd13
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] accumulator;
      logic [7:0] operand;
      logic [7:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] flags_out;
   } rsp_type;

endpackage

@@ rtl/core/cpu8_alu_with_bcd_and_flags.sv @@
// A request accepted into the request register is worked out combinationally and its
// response is loaded into the response register. Throughput: one request per cycle while
// rsp_stall is low; each register advances when it is empty or when the stage after it
// moves on, so back-to-back requests stream through without gaps.
// Reset (synchronous, active high) clears only the two stage valid bits; the block holds
// no architectural state, so nothing else needs clearing.
`timescale 1ns / 1ps

// Top level of the 8-bit ALU with decimal-mode add and subtract.
// Depends on cpu8alu_pkg for the operation codes and payload types.
module cpu8_alu_with_bcd_and_flags (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cpu8alu_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cpu8alu_pkg::rsp_type rsp_data
);
   import cpu8alu_pkg::*;

   // Stage one holds the accepted request; stage two holds the finished response.
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic out_move;
   logic s1_move;

   // The response register can load when it is empty or its content is taken now.
   // The request register can load when it is empty or moves on into the response register.
   // This lets a new request enter while an older response still waits to be taken.
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || out_move;
   assign req_stall = !s1_move;

   assign s1_valid_in  = s1_move  ? req_valid   : s1_valid_ff;
   assign out_valid_in = out_move ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; they load only when their stage advances.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_data_ff <= req_data;
      end
      if (out_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Operand aliases for the computation below.
   logic [7:0] a, v, p;
   logic       cin, borrow;
   assign a      = s1_data_ff.accumulator;
   assign v      = s1_data_ff.operand;
   assign p      = s1_data_ff.flags_in;
   assign cin    = p[FLAG_C];
   assign borrow = !cin;

   // Binary add with carry; bit 8 is the carry out.
   logic [8:0] add_bin;
   assign add_bin = {1'b0, a} + {1'b0, v} + {8'd0, cin};

   // Binary subtract with borrow; bit 8 set means the difference went negative.
   logic [8:0] sub_bin;
   assign sub_bin = {1'b0, a} - {1'b0, v} - {8'd0, borrow};

   // Compare is a subtract without the borrow input.
   logic [8:0] cmp_bin;
   assign cmp_bin = {1'b0, a} - {1'b0, v};

   // Decimal add: correct each digit by six when it passes nine. The low digit's
   // correction carries into the high digit, and the high digit sets the carry.
   logic [5:0] adc_lo_raw, adc_lo, adc_hi_raw, adc_hi;
   logic       adc_lo_over;
   assign adc_lo_raw  = {2'b0, a[3:0]} + {2'b0, v[3:0]} + {5'd0, cin};
   assign adc_lo_over = adc_lo_raw > BCD_MAX_DIGIT;
   assign adc_lo      = adc_lo_over ? adc_lo_raw + BCD_ADJUST : adc_lo_raw;
   assign adc_hi_raw  = {2'b0, a[7:4]} + {2'b0, v[7:4]} + {5'd0, adc_lo_over};
   assign adc_hi      = (adc_hi_raw > BCD_MAX_DIGIT) ? adc_hi_raw + BCD_ADJUST : adc_hi_raw;

   // Decimal subtract: a digit that goes negative is corrected by six and
   // borrows from the next digit. Only four bits of each digit are kept.
   logic [4:0] sbc_lo_raw, sbc_hi_raw;
   logic       sbc_lo_neg, sbc_hi_neg;
   logic [3:0] sbc_lo, sbc_hi;
   assign sbc_lo_raw = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, borrow};
   assign sbc_lo_neg = sbc_lo_raw[4];
   assign sbc_lo     = sbc_lo_neg ? sbc_lo_raw[3:0] - BCD_ADJUST[3:0] : sbc_lo_raw[3:0];
   assign sbc_hi_raw = {1'b0, a[7:4]} - {1'b0, v[7:4]} - {4'd0, sbc_lo_neg};
   assign sbc_hi_neg = sbc_hi_raw[4];
   assign sbc_hi     = sbc_hi_neg ? sbc_hi_raw[3:0] - BCD_ADJUST[3:0] : sbc_hi_raw[3:0];

   // Operation select. Flags not named by an operation pass through; the
   // unused codes return the accumulator and the status byte unchanged.
   always_comb begin
      logic [7:0] res;
      logic [7:0] fl;
      logic       set_nz;
      logic [7:0] nz_val;

      res    = a;
      fl     = p;
      set_nz = 1'b0;
      nz_val = 8'd0;

      case (s1_data_ff.mode)
         MODE_OR: begin
            res    = a | v;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_AND: begin
            res    = a & v;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_XOR: begin
            res    = a ^ v;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_ADC: begin
            // N, Z and V always follow the binary sum, also in decimal mode.
            fl[FLAG_V] = ~(a[7] ^ v[7]) & (a[7] ^ add_bin[7]);
            set_nz     = 1'b1;
            nz_val     = add_bin[7:0];
            if (p[FLAG_D]) begin
               fl[FLAG_C] = adc_hi > BCD_NIBBLE_TOP;
               res        = {adc_hi[3:0], adc_lo[3:0]};
            end else begin
               fl[FLAG_C] = add_bin[8];
               res        = add_bin[7:0];
            end
         end
         MODE_LOAD: begin
            res    = v;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_CMP: begin
            fl[FLAG_C] = !cmp_bin[8];
            set_nz     = 1'b1;
            nz_val     = cmp_bin[7:0];
         end
         MODE_SBC: begin
            fl[FLAG_V] = (a[7] ^ v[7]) & (a[7] ^ sub_bin[7]);
            fl[FLAG_C] = !sub_bin[8];
            set_nz     = 1'b1;
            nz_val     = sub_bin[7:0];
            if (p[FLAG_D]) begin
               res = {sbc_hi, sbc_lo};
            end else begin
               res = sub_bin[7:0];
            end
         end
         MODE_ASL: begin
            fl[FLAG_C] = v[7];
            res        = {v[6:0], 1'b0};
            set_nz     = 1'b1;
            nz_val     = res;
         end
         MODE_ROL: begin
            fl[FLAG_C] = v[7];
            res        = {v[6:0], cin};
            set_nz     = 1'b1;
            nz_val     = res;
         end
         MODE_LSR: begin
            fl[FLAG_C] = v[0];
            res        = {1'b0, v[7:1]};
            set_nz     = 1'b1;
            nz_val     = res;
         end
         MODE_ROR: begin
            fl[FLAG_C] = v[0];
            res        = {cin, v[7:1]};
            set_nz     = 1'b1;
            nz_val     = res;
         end
         MODE_INC: begin
            res    = v + 8'd1;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_DEC: begin
            res    = v - 8'd1;
            set_nz = 1'b1;
            nz_val = res;
         end
         MODE_BIT: begin
            fl[FLAG_Z] = (a & v) == 8'd0;
            fl[FLAG_V] = v[6];
            fl[FLAG_N] = v[7];
         end
         default: begin
            res = a;
            fl  = p;
         end
      endcase

      if (set_nz) begin
         fl[FLAG_Z] = nz_val == 8'd0;
         fl[FLAG_N] = nz_val[7];
      end

      out_data_in.result    = res;
      out_data_in.flags_out = fl;
   end

endmodule
